// ===== hdl/jsud_pkg.sv =====
// ----------------------------------------------------------------------------
// jsud_pkg
// Shared types, character codes and helpers for the JSON string unescape
// decoder.
// ----------------------------------------------------------------------------
package jsud_pkg;

    // scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_SURR     = 3'd4;
    localparam logic [2:0] ERR_EOI      = 3'd5;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       string_done;
        logic [2:0] error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]             cnt;
        t_result [MAX_RES-1:0]  res;
    } t_batch;

    function automatic t_result mk_byte(input logic [7:0] b, input logic is_last);
        t_result r;
        r             = '0;
        r.out_byte    = b;
        r.byte_valid  = 1'b1;
        r.last        = is_last;
        return r;
    endfunction

    function automatic t_result mk_err(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.last       = 1'b1;
        r.error_code = code;
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ===== hdl/jsud_decode.sv =====
// ----------------------------------------------------------------------------
// jsud_decode
// Scan state and single-pass decode of one JSON text byte into up to three
// result items.
// ----------------------------------------------------------------------------
module jsud_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    output jsud_pkg::t_batch o_batch
);

    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_code, n_code;
    logic [4:0]  hex;
    logic [15:0] cu;

    assign hex = jsud_pkg::hex_value(i_byte);
    assign cu  = {r_code[11:0], hex[3:0]};

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_code    = r_code;
        o_batch   = '0;
        if (i_eoi) begin
            n_mode     = jsud_pkg::MODE_IDLE;
            n_hex_cnt  = '0;
            n_code     = '0;
            o_batch.cnt    = 2'd1;
            o_batch.res[0] = jsud_pkg::mk_err(jsud_pkg::ERR_EOI);
        end else begin
            case (r_mode)
                jsud_pkg::MODE_IDLE: begin
                    if (i_byte inside {[jsud_pkg::CH_TAB:jsud_pkg::CH_CR], jsud_pkg::CH_SPACE}) begin
                        // skip whitespace
                    end else if (i_byte == jsud_pkg::CH_QUOTE) begin
                        n_mode = jsud_pkg::MODE_STR;
                    end else begin
                        o_batch.cnt    = 2'd1;
                        o_batch.res[0] = jsud_pkg::mk_err(jsud_pkg::ERR_NO_QUOTE);
                    end
                end
                jsud_pkg::MODE_STR: begin
                    if (i_byte == jsud_pkg::CH_QUOTE) begin
                        n_mode                     = jsud_pkg::MODE_IDLE;
                        o_batch.cnt                = 2'd1;
                        o_batch.res[0]             = '0;
                        o_batch.res[0].last        = 1'b1;
                        o_batch.res[0].string_done = 1'b1;
                    end else if (i_byte == jsud_pkg::CH_BSLASH) begin
                        n_mode = jsud_pkg::MODE_ESC;
                    end else begin
                        o_batch.cnt    = 2'd1;
                        o_batch.res[0] = jsud_pkg::mk_byte(i_byte, 1'b1);
                    end
                end
                jsud_pkg::MODE_ESC: begin
                    n_mode      = jsud_pkg::MODE_STR;
                    o_batch.cnt = 2'd1;
                    case (i_byte)
                        jsud_pkg::CH_QUOTE, jsud_pkg::CH_BSLASH, jsud_pkg::CH_SLASH:
                            o_batch.res[0] = jsud_pkg::mk_byte(i_byte, 1'b1);
                        jsud_pkg::CH_LC_B: o_batch.res[0] = jsud_pkg::mk_byte(jsud_pkg::CH_BS, 1'b1);
                        jsud_pkg::CH_LC_F: o_batch.res[0] = jsud_pkg::mk_byte(jsud_pkg::CH_FF, 1'b1);
                        jsud_pkg::CH_LC_N: o_batch.res[0] = jsud_pkg::mk_byte(jsud_pkg::CH_LF, 1'b1);
                        jsud_pkg::CH_LC_R: o_batch.res[0] = jsud_pkg::mk_byte(jsud_pkg::CH_CR, 1'b1);
                        jsud_pkg::CH_LC_T: o_batch.res[0] = jsud_pkg::mk_byte(jsud_pkg::CH_TAB, 1'b1);
                        jsud_pkg::CH_LC_U: begin
                            n_mode      = jsud_pkg::MODE_HEX;
                            n_hex_cnt   = '0;
                            n_code      = '0;
                            o_batch.cnt = 2'd0;
                        end
                        default: begin
                            n_mode         = jsud_pkg::MODE_IDLE;
                            n_hex_cnt      = '0;
                            n_code         = '0;
                            o_batch.res[0] = jsud_pkg::mk_err(jsud_pkg::ERR_BAD_ESC);
                        end
                    endcase
                end
                default: begin
                    if (!hex[4]) begin
                        n_mode         = jsud_pkg::MODE_IDLE;
                        n_hex_cnt      = '0;
                        n_code         = '0;
                        o_batch.cnt    = 2'd1;
                        o_batch.res[0] = jsud_pkg::mk_err(jsud_pkg::ERR_BAD_HEX);
                    end else if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                        n_code    = cu;
                    end else begin
                        n_hex_cnt = '0;
                        n_code    = '0;
                        if (cu[15:11] == 5'b11011) begin
                            n_mode         = jsud_pkg::MODE_IDLE;
                            o_batch.cnt    = 2'd1;
                            o_batch.res[0] = jsud_pkg::mk_err(jsud_pkg::ERR_SURR);
                        end else begin
                            n_mode = jsud_pkg::MODE_STR;
                            if (cu[15:7] == '0) begin
                                o_batch.cnt    = 2'd1;
                                o_batch.res[0] = jsud_pkg::mk_byte({1'b0, cu[6:0]}, 1'b1);
                            end else if (cu[15:11] == '0) begin
                                o_batch.cnt    = 2'd2;
                                o_batch.res[0] = jsud_pkg::mk_byte({3'b110, cu[10:6]}, 1'b0);
                                o_batch.res[1] = jsud_pkg::mk_byte({2'b10, cu[5:0]}, 1'b1);
                            end else begin
                                o_batch.cnt    = 2'd3;
                                o_batch.res[0] = jsud_pkg::mk_byte({4'b1110, cu[15:12]}, 1'b0);
                                o_batch.res[1] = jsud_pkg::mk_byte({2'b10, cu[11:6]}, 1'b0);
                                o_batch.res[2] = jsud_pkg::mk_byte({2'b10, cu[5:0]}, 1'b1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsud_pkg::MODE_IDLE;
            r_hex_cnt <= '0;
            r_code    <= '0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_code    <= n_code;
        end
    end

endmodule

// ===== hdl/jsud_out_buf.sv =====
// ----------------------------------------------------------------------------
// jsud_out_buf
// Result register: holds the up to three results of one item and hands
// them out one transfer at a time.
// ----------------------------------------------------------------------------
module jsud_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsud_pkg::t_batch i_batch,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output jsud_pkg::t_result o_res
);

    jsud_pkg::t_result [jsud_pkg::MAX_RES-1:0] r_res;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       xfer;

    assign o_valid = (r_cnt != 2'd0);
    assign xfer    = o_valid && i_ready;
    // free when empty or the final result leaves this cycle
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_res   = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (xfer) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result register loaded while still holding results");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_idx} + {1'b0, r_cnt}) <= 3'd3)
        else $error("result index past end of batch");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.last == (r_cnt == 2'd1)))
        else $error("last flag does not match final result");

    a_mid_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |-> (o_res.byte_valid && o_res.error_code == 3'd0))
        else $error("non-final result is not a plain byte");

endmodule

// ===== hdl/json_string_unescape_decoder.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_decoder
// Decodes JSON strings from a byte stream: escapes, \u to UTF-8, errors.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_ready | i_in_byte, i_end_of_input
//   output  | o_valid | i_ready | o_out_byte, o_byte_valid, o_last,
//           |         |         | o_string_done, o_error_code
//
// One byte per cycle while the result register is free; an item waits in the
// input register, then moves to the result register with all of its results
// decoded. A \u escape of two or three UTF-8 bytes holds the input while the
// result register drains.
// Output stalls back up through the result and input registers.
// Reset (synchronous, active low) empties both registers and returns the
// scan to idle.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_string_done,
    output logic [2:0] o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       buf_free;
    logic       advance;

    jsud_pkg::t_batch  batch;
    jsud_pkg::t_result res;

    assign advance = r_in_valid && buf_free;
    assign o_ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    jsud_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_eoi     (r_in_eoi),
        .o_batch   (batch)
    );

    jsud_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_batch (batch),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_byte    = res.out_byte;
    assign o_byte_valid  = res.byte_valid;
    assign o_last        = res.last;
    assign o_string_done = res.string_done;
    assign o_error_code  = res.error_code;

endmodule
